FILE: hdl/cti_pkg.sv
// shared types, constants and codes for the calibration table interpolator
// no dependencies; imported by cti_ctrl, cti_dpath and calibration_table_interpolator
package cti_pkg;

    localparam int MAX_POINTS_DEF = 8;

    // field widths
    localparam int PW   = 16;   // point / request power, unsigned
    localparam int VW   = 16;   // voltage, signed
    localparam int IDXW = 3;    // point_index
    localparam int CNTW = 4;    // point_count register

    // stream and register port widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 16;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    // register byte addresses
    localparam logic [APB_AW-1:0] REG_POINT_COUNT = 3'd0;

    // item commands
    localparam logic CMD_CONVERT = 1'b0;
    localparam logic CMD_LOAD    = 1'b1;

    // table read kinds
    localparam logic RD_MINMAX  = 1'b0;
    localparam logic RD_SEGMENT = 1'b1;

    // serial divider: 32-bit magnitude by 16-bit magnitude, one quotient bit per cycle
    localparam int DIV_STEPS = 32;
    localparam int DIV_CW    = 5;

    // result source codes
    typedef logic [2:0] t_res_src;
    localparam t_res_src RES_ZERO   = 3'd0;
    localparam t_res_src RES_LO     = 3'd1;
    localparam t_res_src RES_HI     = 3'd2;
    localparam t_res_src RES_V0     = 3'd3;
    localparam t_res_src RES_INTERP = 3'd4;

    // commands from the controller to the datapath
    typedef struct packed {
        logic     we;
        logic     req_ld;
        logic     rd_en;
        logic     rd_kind;
        logic     rd_first;
        logic     mul_go;
        logic     div_init;
        logic     div_step;
        logic     res_ld;
        t_res_src res_src;
    } t_cti_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic clamp_lo;
        logic clamp_hi;
        logic seg_found;
        logic seg_flat;
        logic out_free;
    } t_cti_stat;

endpackage

FILE: hdl/calibration_table_interpolator.sv
// top level: stream ports, point_count register on the apb-style port, controller and datapath
// depends on cti_pkg, cti_ctrl, cti_dpath
//
//   channel   dir  handshake             payload
//   s stream  in   i_s_tvalid/o_s_tready cmd, point_index, point_power, point_voltage, request
//   m stream  out  o_m_tvalid/i_m_tready control_voltage
//   config    in   psel/penable/pwrite   point_count at byte address 0
//
// a load item is written to the point memory when it is taken; a convert runs two scans
// of the n points in use, one read per cycle, and a 32-step serial divider;
// clamped results skip the second scan and the divider, and no points gives a zero result
// reset clears control state and point_count; the point memory is not cleared
// a finished result waits in the output register; the next item is taken meanwhile, but
// a second convert holds its result until the first is taken
module calibration_table_interpolator
    import cti_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // s_tdata: cmd[0], point_index[3:1], point_power[19:4], point_voltage[35:20],
    // request_power[51:36], zero fill[55:52]
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // m_tdata: control_voltage[15:0]
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [APB_AW-1:0]    i_paddr,
    input  logic [APB_DW-1:0]    i_pwdata,
    output logic [APB_DW-1:0]    o_prdata,
    output logic                 o_pready
);

    localparam int AW = $clog2(MAX_POINTS);

    logic [CNTW-1:0]      r_point_count;
    t_cti_cmd             w_cmd;
    t_cti_stat            w_stat;
    logic [AW-1:0]        w_rd_addr;
    logic signed [VW-1:0] w_voltage;

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr == REG_POINT_COUNT) ? APB_DW'(r_point_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
        end else if (i_psel && i_penable && i_pwrite && o_pready
                     && i_paddr == REG_POINT_COUNT) begin
            r_point_count <= i_pwdata[CNTW-1:0];
        end
    end

    cti_ctrl #(
        .MAX_POINTS(MAX_POINTS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_cmd         (i_s_tdata[0]),
        .i_point_count (r_point_count),
        .i_stat        (w_stat),
        .o_s_tready    (o_s_tready),
        .o_cmd         (w_cmd),
        .o_rd_addr     (w_rd_addr)
    );

    cti_dpath #(
        .MAX_POINTS(MAX_POINTS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_rd_addr         (w_rd_addr),
        .i_point_index     (i_s_tdata[3:1]),
        .i_point_power     (i_s_tdata[19:4]),
        .i_point_voltage   ($signed(i_s_tdata[35:20])),
        .i_request_power   (i_s_tdata[51:36]),
        .i_m_tready        (i_m_tready),
        .o_stat            (w_stat),
        .o_res_valid       (o_m_tvalid),
        .o_control_voltage (w_voltage)
    );

    assign o_m_tdata = w_voltage;

    // a result is loaded only into a free output register
    a_res_ld_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.res_ld |-> (!o_m_tvalid || i_m_tready))
        else $error("result loaded over an unclaimed result");

    // the memory is written only by an accepted load item
    a_we_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.we |-> (i_s_tvalid && o_s_tready && i_s_tdata[0] == CMD_LOAD))
        else $error("point write without an accepted load item");

    // a load item never produces a result in the following cycle
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tdata[0] == CMD_LOAD) |=> !w_cmd.res_ld)
        else $error("load item produced a result");

    // datapath operations are exclusive
    a_ops_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.rd_en, w_cmd.mul_go, w_cmd.div_init, w_cmd.div_step, w_cmd.res_ld}))
        else $error("overlapping datapath commands");

endmodule

FILE: hdl/cti_ctrl.sv
// controller state machine: sequences table scans, multiply, serial divide and result
// depends on cti_pkg
module cti_ctrl
    import cti_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_cmd,
    input  logic [CNTW-1:0]               i_point_count,
    input  t_cti_stat                     i_stat,
    output logic                          o_s_tready,
    output t_cti_cmd                      o_cmd,
    output logic [$clog2(MAX_POINTS)-1:0] o_rd_addr
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = ($clog2(MAX_POINTS + 1) > CNTW) ? $clog2(MAX_POINTS + 1) : CNTW;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MM    = 4'd1;
    localparam logic [3:0] ST_MM_W  = 4'd2;
    localparam logic [3:0] ST_CLAMP = 4'd3;
    localparam logic [3:0] ST_SEG   = 4'd4;
    localparam logic [3:0] ST_SEG_W = 4'd5;
    localparam logic [3:0] ST_EVAL  = 4'd6;
    localparam logic [3:0] ST_MUL   = 4'd7;
    localparam logic [3:0] ST_DINIT = 4'd8;
    localparam logic [3:0] ST_DIV   = 4'd9;
    localparam logic [3:0] ST_FIN   = 4'd10;

    logic [3:0]        r_state, n_state;
    logic [NW-1:0]     r_cnt, n_cnt;
    logic [DIV_CW-1:0] r_dcnt, n_dcnt;
    t_res_src          r_src, n_src;
    logic [NW-1:0]     w_n;
    logic              w_last;
    logic              w_accept;

    // counts above capacity use the whole table
    assign w_n = (NW'(i_point_count) > NW'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(i_point_count);
    assign w_last     = (r_cnt == (w_n - NW'(1)));
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_rd_addr  = r_cnt[AW-1:0];

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_dcnt  = r_dcnt;
        n_src   = r_src;
        o_cmd   = '0;
        o_cmd.res_src = r_src;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_cmd == CMD_LOAD) begin
                        o_cmd.we = 1'b1;
                    end else begin
                        o_cmd.req_ld = 1'b1;
                        n_cnt = '0;
                        if (w_n == '0) begin
                            n_src   = RES_ZERO;
                            n_state = ST_FIN;
                        end else begin
                            n_state = ST_MM;
                        end
                    end
                end
            end
            ST_MM: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_kind  = RD_MINMAX;
                o_cmd.rd_first = (r_cnt == '0);
                if (w_last) begin
                    n_state = ST_MM_W;
                end else begin
                    n_cnt = r_cnt + NW'(1);
                end
            end
            ST_MM_W: begin
                n_state = ST_CLAMP;
            end
            ST_CLAMP: begin
                if (i_stat.clamp_lo) begin
                    n_src   = RES_LO;
                    n_state = ST_FIN;
                end else if (i_stat.clamp_hi) begin
                    n_src   = RES_HI;
                    n_state = ST_FIN;
                end else begin
                    n_cnt   = '0;
                    n_state = ST_SEG;
                end
            end
            ST_SEG: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_kind  = RD_SEGMENT;
                o_cmd.rd_first = (r_cnt == '0);
                if (w_last) begin
                    n_state = ST_SEG_W;
                end else begin
                    n_cnt = r_cnt + NW'(1);
                end
            end
            ST_SEG_W: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (!i_stat.seg_found) begin
                    n_src   = RES_HI;
                    n_state = ST_FIN;
                end else if (i_stat.seg_flat) begin
                    n_src   = RES_V0;
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_go = 1'b1;
                n_state = ST_DINIT;
            end
            ST_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_dcnt  = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_dcnt == DIV_CW'(DIV_STEPS - 1)) begin
                    n_src   = RES_INTERP;
                    n_state = ST_FIN;
                end else begin
                    n_dcnt = r_dcnt + DIV_CW'(1);
                end
            end
            ST_FIN: begin
                // wait here while the previous result is still unclaimed
                if (i_stat.out_free) begin
                    o_cmd.res_ld = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_dcnt  <= '0;
            r_src   <= RES_ZERO;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_dcnt  <= n_dcnt;
            r_src   <= n_src;
        end
    end

endmodule

FILE: hdl/cti_dpath.sv
// datapath: point memory, min/max and segment trackers, multiplier, serial divider,
// result register; depends on cti_pkg
module cti_dpath
    import cti_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cti_cmd                      i_cmd,
    input  logic [$clog2(MAX_POINTS)-1:0] i_rd_addr,
    input  logic [IDXW-1:0]               i_point_index,
    input  logic [PW-1:0]                 i_point_power,
    input  logic signed [VW-1:0]          i_point_voltage,
    input  logic [PW-1:0]                 i_request_power,
    input  logic                          i_m_tready,
    output t_cti_stat                     o_stat,
    output logic                          o_res_valid,
    output logic signed [VW-1:0]          o_control_voltage
);

    localparam int AW = $clog2(MAX_POINTS);

    logic [PW+VW-1:0] r_mem [MAX_POINTS];
    logic [PW+VW-1:0] r_rd_data;
    logic             r_rd_valid, r_rd_kind, r_rd_first;
    logic             w_idx_ok;
    logic [AW-1:0]    w_waddr;
    logic [PW-1:0]    w_rd_p;
    logic signed [VW-1:0] w_rd_v;

    logic [PW-1:0]        r_req;
    logic [PW-1:0]        r_lo_p, r_hi_p, r_prev_p, r_p0, r_p1;
    logic signed [VW-1:0] r_lo_v, r_hi_v, r_prev_v, r_v0, r_v1;
    logic                 r_found;
    logic [PW-1:0]        w_smin, w_smax;
    logic                 w_in_seg;

    logic signed [PW+1:0]   w_dp, w_dv, w_den;
    logic signed [2*PW+1:0] r_prod;
    logic signed [PW:0]     r_den;
    logic [2*PW+1:0]        w_num_mag;
    logic [PW:0]            w_den_mag;
    logic                   r_neg;
    logic [PW-1:0]          r_rem, r_dmag;
    logic [2*PW-1:0]        r_quo;
    logic [PW:0]            w_shift, w_sub;
    logic                   w_ge;
    logic signed [VW+1:0]   w_qs, w_interp;

    logic                 r_res_valid;
    logic signed [VW-1:0] r_res, w_res;

    // point memory
    assign w_idx_ok = (32'(i_point_index) < MAX_POINTS);
    assign w_waddr  = AW'(i_point_index);

    always_ff @(posedge i_clk) begin
        if (i_cmd.we && w_idx_ok) begin
            r_mem[w_waddr] <= {i_point_power, i_point_voltage};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_rd_kind  <= RD_MINMAX;
            r_rd_first <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.rd_en;
            r_rd_kind  <= i_cmd.rd_kind;
            r_rd_first <= i_cmd.rd_first;
        end
    end

    assign w_rd_p = r_rd_data[PW+VW-1:VW];
    assign w_rd_v = $signed(r_rd_data[VW-1:0]);

    assign w_smin   = (r_prev_p < w_rd_p) ? r_prev_p : w_rd_p;
    assign w_smax   = (r_prev_p < w_rd_p) ? w_rd_p : r_prev_p;
    assign w_in_seg = (r_req >= w_smin) && (r_req <= w_smax);

    // scans: strict compares keep the first-found extreme and the first segment
    always_ff @(posedge i_clk) begin
        if (i_cmd.req_ld) begin
            r_req <= i_request_power;
        end
        if (r_rd_valid && r_rd_kind == RD_MINMAX) begin
            if (r_rd_first || w_rd_p < r_lo_p) begin
                r_lo_p <= w_rd_p;
                r_lo_v <= w_rd_v;
            end
            if (r_rd_first || w_rd_p > r_hi_p) begin
                r_hi_p <= w_rd_p;
                r_hi_v <= w_rd_v;
            end
        end
        if (r_rd_valid && r_rd_kind == RD_SEGMENT) begin
            r_prev_p <= w_rd_p;
            r_prev_v <= w_rd_v;
            if (!r_rd_first && !r_found && w_in_seg) begin
                r_p0 <= r_prev_p;
                r_v0 <= r_prev_v;
                r_p1 <= w_rd_p;
                r_v1 <= w_rd_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (r_rd_valid && r_rd_kind == RD_SEGMENT) begin
            if (r_rd_first) begin
                r_found <= 1'b0;
            end else if (w_in_seg) begin
                r_found <= 1'b1;
            end
        end
    end

    // (p - p0) * (v1 - v0), then magnitudes for the divider
    assign w_dp  = $signed({2'b00, r_req}) - $signed({2'b00, r_p0});
    assign w_dv  = $signed({{2{r_v1[VW-1]}}, r_v1}) - $signed({{2{r_v0[VW-1]}}, r_v0});
    assign w_den = $signed({2'b00, r_p1}) - $signed({2'b00, r_p0});

    assign w_num_mag = r_prod[2*PW+1] ? (2*PW+2)'(-r_prod) : (2*PW+2)'(r_prod);
    assign w_den_mag = r_den[PW] ? (PW+1)'(-r_den) : (PW+1)'(r_den);

    assign w_shift = {r_rem, r_quo[2*PW-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dmag});
    assign w_sub   = w_shift - {1'b0, r_dmag};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_go) begin
            r_prod <= w_dp * w_dv;
            r_den  <= w_den[PW:0];
        end
        if (i_cmd.div_init) begin
            r_neg  <= r_prod[2*PW+1] ^ r_den[PW];
            r_quo  <= w_num_mag[2*PW-1:0];
            r_dmag <= w_den_mag[PW-1:0];
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_sub[PW-1:0] : w_shift[PW-1:0];
            r_quo <= {r_quo[2*PW-2:0], w_ge};
        end
    end

    // quotient magnitude never exceeds |v1 - v0|, so 17 bits carry it
    assign w_qs     = r_neg ? -$signed({1'b0, r_quo[PW:0]}) : $signed({1'b0, r_quo[PW:0]});
    assign w_interp = $signed({{2{r_v0[VW-1]}}, r_v0}) + w_qs;

    always_comb begin
        case (i_cmd.res_src)
            RES_ZERO:   w_res = '0;
            RES_LO:     w_res = r_lo_v;
            RES_HI:     w_res = r_hi_v;
            RES_V0:     w_res = r_v0;
            RES_INTERP: w_res = w_interp[VW-1:0];
            default:    w_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_ld) begin
            r_res <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_cmd.res_ld) begin
            r_res_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_res_valid <= 1'b0;
        end
    end

    assign o_stat.clamp_lo  = (r_req <= r_lo_p);
    assign o_stat.clamp_hi  = (r_req >= r_hi_p);
    assign o_stat.seg_found = r_found;
    assign o_stat.seg_flat  = (r_p0 == r_p1);
    assign o_stat.out_free  = !r_res_valid || i_m_tready;

    assign o_res_valid       = r_res_valid;
    assign o_control_voltage = r_res;

endmodule

FILE: bench/tb.sv
// testbench for calibration_table_interpolator: loads calibration points, converts powers
// and checks every voltage against an in-bench piecewise linear predictor
// depends on cti_pkg and the calibration_table_interpolator rtl
module tb;
    import cti_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS          = MAX_POINTS_DEF;
    localparam int SETTLE_CYCLES = 2 * NPTS + 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int RAND_ROUNDS   = 5;
    localparam int ROUND_ITEMS   = 43;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 i_psel     = 1'b0;
    logic                 i_penable  = 1'b0;
    logic                 i_pwrite   = 1'b0;
    logic [APB_AW-1:0]    i_paddr    = '0;
    logic [APB_DW-1:0]    i_pwdata   = '0;
    logic [APB_DW-1:0]    o_prdata;
    logic                 o_pready;

    // predictor copy of the table and the point_count register
    logic [PW-1:0]        cal_power [NPTS];
    logic signed [VW-1:0] cal_volt  [NPTS];
    logic [CNTW-1:0]      cal_count = '0;

    logic signed [VW-1:0] voltage_q [$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          hold_start    = 0;
    int          hold_seen     = 0;
    int          hold_left     = 0;
    int          fail_count    = 0;
    int          n_loads       = 0;
    int          n_converts    = 0;
    int          n_results     = 0;
    int          n_cfg         = 0;

    calibration_table_interpolator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    always #4 i_clk = ~i_clk;

    function automatic void note_failure(input string msg);
        if (fail_count < 10) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
        fail_count++;
    endfunction

    function automatic logic signed [VW-1:0] predict_voltage(input logic [PW-1:0] req);
        int     n;
        int     lo;
        int     hi;
        longint p;
        longint p0;
        longint p1;
        longint v0;
        longint v1;
        longint smin;
        longint smax;
        n  = (cal_count > NPTS) ? NPTS : int'(cal_count);
        lo = 0;
        hi = 0;
        p  = longint'(req);
        if (n == 0) begin
            return '0;
        end
        if (n == 1) begin
            return cal_volt[0];
        end
        for (int i = 1; i < n; i++) begin
            if (cal_power[i] < cal_power[lo]) lo = i;
            if (cal_power[i] > cal_power[hi]) hi = i;
        end
        p0 = longint'(cal_power[lo]);
        p1 = longint'(cal_power[hi]);
        if (p <= p0) begin
            return cal_volt[lo];
        end
        if (p >= p1) begin
            return cal_volt[hi];
        end
        for (int i = 1; i < n; i++) begin
            p0   = longint'(cal_power[i-1]);
            p1   = longint'(cal_power[i]);
            smin = (p0 < p1) ? p0 : p1;
            smax = (p0 < p1) ? p1 : p0;
            if (p >= smin && p <= smax) begin
                v0 = longint'(cal_volt[i-1]);
                v1 = longint'(cal_volt[i]);
                if (p1 == p0) begin
                    return VW'(v0);
                end
                // signed division truncates toward zero
                return VW'(v0 + ((p - p0) * (v1 - v0)) / (p1 - p0));
            end
        end
        return cal_volt[hi];
    endfunction

    // append one predicted voltage behind the ones already waiting
    function automatic void enqueue_voltage(input logic signed [VW-1:0] v);
        voltage_q.insert(voltage_q.size(), v);
    endfunction

    // send one item; valid stays high into the next item when no gap is drawn
    task automatic send_item(input logic cmd, input logic [IDXW-1:0] idx,
                             input logic [PW-1:0] pw, input logic [VW-1:0] pv,
                             input logic [PW-1:0] rq);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(S_TDATA_W-52){1'b0}}, rq, pv, pw, idx, cmd};
        do @(posedge i_clk); while (!o_s_tready);
        if (cmd == CMD_LOAD) begin
            if (idx < NPTS) begin
                cal_power[idx] = pw;
                cal_volt[idx]  = pv;
            end
            n_loads++;
        end else begin
            enqueue_voltage(predict_voltage(rq));
            n_converts++;
        end
    endtask

    task automatic load_point(input int idx, input int pw, input int pv);
        send_item(CMD_LOAD, IDXW'(idx), PW'(pw), VW'(pv), PW'($urandom));
    endtask

    task automatic convert(input int rq);
        send_item(CMD_CONVERT, IDXW'($urandom), PW'($urandom), VW'($urandom), PW'(rq));
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (voltage_q.size() != 0) @(posedge i_clk);
        // a trailing load may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= wr;
        i_paddr   <= REG_POINT_COUNT;
        i_pwdata  <= wdata;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        rdata = o_prdata;
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
    endtask

    task automatic check_count_readback();
        logic [APB_DW-1:0] rd;
        apb_xfer(1'b0, '0, rd);
        if (rd !== APB_DW'(cal_count)) begin
            note_failure($sformatf("point_count read: expected %0d, got %0d", cal_count, rd));
        end
    endtask

    task automatic set_point_count(input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] rd;
        wait_idle();
        apb_xfer(1'b1, value, rd);
        cal_count = value[CNTW-1:0];
        n_cfg++;
        check_count_readback();
    endtask

    // result side: random or long hold-off on tready, compare each accepted item
    always @(posedge i_clk) begin
        logic signed [VW-1:0] want;
        if (hold_start != hold_seen) begin
            hold_seen  <= hold_start;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_results++;
            if (voltage_q.size() == 0) begin
                note_failure($sformatf("unexpected control_voltage %0d",
                                       $signed(o_m_tdata)));
            end else begin
                want = voltage_q.pop_front();
                if (o_m_tdata !== want) begin
                    note_failure($sformatf("control_voltage: expected %0d, got %0d",
                                           want, $signed(o_m_tdata)));
                end
            end
        end
    end

    task automatic test_register_reset();
        check_count_readback();
    endtask

    // unsorted table: flat first segment, repeated min and max powers, voltage extremes;
    // every slot is written here, so no later convert reads an unwritten slot
    task automatic test_load_table();
        load_point(0, 30000, 5000);
        load_point(1, 30000, -7000);
        load_point(2, 0, -32768);
        load_point(3, 65535, 32767);
        load_point(4, 10000, 200);
        load_point(5, 0, 999);
        load_point(6, 65535, -1);
        load_point(7, 20000, 1000);
    endtask

    task automatic test_empty_and_single();
        set_point_count(0);
        convert(12345);
        set_point_count(1);
        convert(65535);
    endtask

    task automatic test_clamp_and_interp();
        set_point_count(2);
        convert(29999);
        convert(30001);
        set_point_count(8);
        convert(0);
        convert(65535);
        convert(30000);
        convert(15000);
        convert(1);
        convert(65534);
        convert(10000);
        convert(40000);
    endtask

    task automatic test_count_above_capacity();
        set_point_count(9);
        convert(5000);
        set_point_count(15);
        convert(50000);
    endtask

    task automatic test_backpressure();
        set_point_count(8);
        hold_start++;
        repeat (8) convert($urandom_range(65535));
    endtask

    task automatic random_item();
        int k;
        int rq;
        int pw;
        int pv;
        if ($urandom_range(99) < 30) begin
            case ($urandom_range(3))
                0:       pw = 0;
                1:       pw = 65535;
                2:       pw = int'(cal_power[$urandom_range(NPTS-1)]);
                default: pw = $urandom_range(65535);
            endcase
            case ($urandom_range(4))
                0:       pv = -32768;
                1:       pv = 32767;
                default: pv = int'($urandom_range(65535)) - 32768;
            endcase
            load_point($urandom_range(NPTS-1), pw, pv);
        end else begin
            k = $urandom_range(NPTS-2);
            case ($urandom_range(5))
                0:       rq = $urandom_range(65535);
                1:       rq = int'(cal_power[k]);
                2:       rq = (int'(cal_power[k]) + ($urandom_range(1) ? 1 : -1)) & 16'hffff;
                3:       rq = $urandom_range(1) ? 65535 : 0;
                4:       rq = (int'(cal_power[k]) + int'(cal_power[k+1])) / 2;
                default: rq = $urandom_range(65535);
            endcase
            convert(rq);
        end
    endtask

    task automatic test_random();
        logic [APB_DW-1:0] cnt;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 13; recv_idle_pct = 88; end
                1: begin send_idle_pct = 88; recv_idle_pct = 13; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int r = 0; r < RAND_ROUNDS; r++) begin
                cnt = $urandom;
                case ($urandom_range(6))
                    0:       cnt[CNTW-1:0] = CNTW'(0);
                    1:       cnt[CNTW-1:0] = CNTW'(1);
                    2:       cnt[CNTW-1:0] = CNTW'(2);
                    3:       cnt[CNTW-1:0] = CNTW'(15);
                    4:       cnt[CNTW-1:0] = CNTW'(NPTS);
                    default: cnt[CNTW-1:0] = CNTW'($urandom_range(15));
                endcase
                set_point_count(cnt);
                repeat (ROUND_ITEMS) random_item();
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_reset();
        test_load_table();
        test_empty_and_single();
        test_clamp_and_interp();
        test_count_above_capacity();
        test_backpressure();
        test_random();
        wait_idle();
        if (voltage_q.size() != 0) begin
            note_failure($sformatf("%0d control_voltage items never arrived",
                                   voltage_q.size()));
        end
        $display("covered %0d loads and %0d converts, %0d voltages checked, %0d point_count writes",
                 n_loads, n_converts, n_results, n_cfg);
        $display("sender and receiver idling swapped between phases, one long receiver hold-off");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #6ms;
        $display("timeout with %0d voltages outstanding", voltage_q.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
